// File: rtl/tmac_pkg.sv
// shared types and constants for the touch median-of-seven calibration block
package tmac_pkg;

   localparam int GROUP_LEN  = 7;
   localparam int MEDIAN_SEL = 3;
   localparam int NET_LEN    = 13;
   localparam int COEF_W     = 32;
   localparam int POINT_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CNT_W      = 3;

   typedef logic [2:0] slot_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic signed [COEF_W-1:0] coef_type;
   typedef logic signed [POINT_W-1:0] point_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_AX   = 3'd0,
      CSR_COEF_BX   = 3'd1,
      CSR_OFFSET_DX = 3'd2,
      CSR_COEF_AY   = 3'd3,
      CSR_COEF_BY   = 3'd4,
      CSR_OFFSET_DY = 3'd5,
      CSR_RAW_MODE  = 3'd6
   } csr_reg_type;

   localparam coef_type COEF_UNITY = 32'sd65536;

   // compare-exchange pairs of the median-of-seven network, applied in order
   localparam slot_type NET_LO [NET_LEN] = '{
      3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd3, 3'd2,
      3'd2, 3'd3, 3'd4, 3'd1, 3'd1, 3'd3
   };
   localparam slot_type NET_HI [NET_LEN] = '{
      3'd5, 3'd3, 3'd6, 3'd4, 3'd1, 3'd5, 3'd6,
      3'd3, 3'd6, 3'd5, 3'd4, 3'd3, 3'd4
   };

endpackage

// File: rtl/tmac_req_if.sv
// sample channel: raw touch pair plus pen state
interface tmac_req_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] raw_x;
   logic [SAMPLE_BITS-1:0] raw_y;
   logic                   pen_down;

   modport source (output valid, output raw_x, output raw_y, output pen_down, input ready);
   modport sink   (input valid, input raw_x, input raw_y, input pen_down, output ready);
endinterface

// File: rtl/tmac_rsp_if.sv
// point channel: calibrated touch coordinate
interface tmac_rsp_if;
   logic                 valid;
   logic                 ready;
   tmac_pkg::point_type  point_x;
   tmac_pkg::point_type  point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// File: rtl/tmac_median7.sv
// median-of-seven exchange network for one axis
module tmac_median7 #(
   parameter int WIDTH = 12
) (
   input  logic [WIDTH-1:0] samples [tmac_pkg::GROUP_LEN],
   output logic [WIDTH-1:0] median
);

   logic [WIDTH-1:0] work [tmac_pkg::GROUP_LEN];

   always_comb begin
      logic [WIDTH-1:0] lo_val;
      logic [WIDTH-1:0] hi_val;
      work = samples;
      for (int k = 0; k < tmac_pkg::NET_LEN; k++) begin
         lo_val = work[tmac_pkg::NET_LO[k]];
         hi_val = work[tmac_pkg::NET_HI[k]];
         if (lo_val > hi_val) begin
            work[tmac_pkg::NET_LO[k]] = hi_val;
            work[tmac_pkg::NET_HI[k]] = lo_val;
         end
      end
   end

   assign median = work[tmac_pkg::MEDIAN_SEL];

endmodule

// File: rtl/touch_median7_affine_calibrate_top.sv
// the seventh word of a group sets fire_ff; its point moves through med, prod, acc and rsp registers
// throughput: one sample word per cycle while not stalled; one point per seven pen-down words
// stages: sample buffer, median network, coefficient multiply, sum, round and saturate
// the pipe stalls only while a point waits on the rsp side and the next sits in the sum stage
// synchronous reset clears the group count, stage valids and loads default coefficients
// the sample buffer itself is not cleared
module touch_median7_affine_calibrate_top #(
   parameter int SAMPLE_BITS = 12,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   tmac_req_if.sink                            req_ch,
   tmac_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [tmac_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tmac_pkg::COEF_W-1:0]         csr_wdata
);

   localparam int PROD_W = tmac_pkg::COEF_W + SAMPLE_BITS + 1;
   localparam int ACC_W  = PROD_W + 2;
   localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(-32768);
   localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'((64'sd1 <<< FRAC_BITS) - 1);
   localparam logic signed [ACC_W-1:0] NO_BIAS  = '0;

   // configuration
   tmac_pkg::coef_type coef_ax_ff, coef_bx_ff, offset_dx_ff;
   tmac_pkg::coef_type coef_ay_ff, coef_by_ff, offset_dy_ff;
   logic               raw_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ax_ff   <= tmac_pkg::COEF_UNITY;
         coef_bx_ff   <= '0;
         offset_dx_ff <= '0;
         coef_ay_ff   <= '0;
         coef_by_ff   <= tmac_pkg::COEF_UNITY;
         offset_dy_ff <= '0;
         raw_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            tmac_pkg::CSR_COEF_AX:   coef_ax_ff   <= csr_wdata;
            tmac_pkg::CSR_COEF_BX:   coef_bx_ff   <= csr_wdata;
            tmac_pkg::CSR_OFFSET_DX: offset_dx_ff <= csr_wdata;
            tmac_pkg::CSR_COEF_AY:   coef_ay_ff   <= csr_wdata;
            tmac_pkg::CSR_COEF_BY:   coef_by_ff   <= csr_wdata;
            tmac_pkg::CSR_OFFSET_DY: offset_dy_ff <= csr_wdata;
            tmac_pkg::CSR_RAW_MODE:  raw_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipe control
   logic rsp_valid_ff;
   logic acc_vld_ff;
   logic out_free;
   logic advance;
   logic take;

   // the front only waits when a finished point cannot move into a full rsp register
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = out_free || !acc_vld_ff;
   assign take         = req_ch.valid && advance;
   assign req_ch.ready = advance;

   // sample buffer and group count
   logic [SAMPLE_BITS-1:0] x_buf_ff [tmac_pkg::GROUP_LEN];
   logic [SAMPLE_BITS-1:0] y_buf_ff [tmac_pkg::GROUP_LEN];
   tmac_pkg::count_type    count_ff;
   logic                   fire_ff;
   logic                   last_slot;

   assign last_slot = (count_ff == tmac_pkg::CNT_W'(tmac_pkg::GROUP_LEN - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fire_ff  <= 1'b0;
      end else if (advance) begin
         fire_ff <= take && req_ch.pen_down && last_slot;
         if (take) begin
            if (!req_ch.pen_down || last_slot) begin
               count_ff <= '0;
            end else begin
               count_ff <= count_ff + tmac_pkg::count_type'(1);
            end
         end
      end
   end

   // order inside the buffer does not matter to the median, so just shift in
   always_ff @(posedge clock) begin
      if (take && req_ch.pen_down) begin
         x_buf_ff[0] <= req_ch.raw_x;
         y_buf_ff[0] <= req_ch.raw_y;
         for (int k = 1; k < tmac_pkg::GROUP_LEN; k++) begin
            x_buf_ff[k] <= x_buf_ff[k-1];
            y_buf_ff[k] <= y_buf_ff[k-1];
         end
      end
   end

   // median stage
   logic [SAMPLE_BITS-1:0] med_x, med_y;
   logic [SAMPLE_BITS-1:0] med_x_ff, med_y_ff;
   logic                   med_vld_ff;

   tmac_median7 #(.WIDTH(SAMPLE_BITS)) u_med_x (.samples(x_buf_ff), .median(med_x));
   tmac_median7 #(.WIDTH(SAMPLE_BITS)) u_med_y (.samples(y_buf_ff), .median(med_y));

   always_ff @(posedge clock) begin
      if (reset) begin
         med_vld_ff <= 1'b0;
      end else if (advance) begin
         med_vld_ff <= fire_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         med_x_ff <= med_x;
         med_y_ff <= med_y;
      end
   end

   // multiply stage
   logic signed [PROD_W-1:0]     prod_ax_ff, prod_bx_ff, prod_ay_ff, prod_by_ff;
   logic signed [PROD_W-1:0]     prod_ax_in, prod_bx_in, prod_ay_in, prod_by_in;
   logic signed [SAMPLE_BITS:0]  mx_s, my_s;
   logic [SAMPLE_BITS-1:0]       med3_x_ff, med3_y_ff;
   logic                         prod_vld_ff;

   assign mx_s = $signed({1'b0, med_x_ff});
   assign my_s = $signed({1'b0, med_y_ff});
   assign prod_ax_in = PROD_W'(coef_ax_ff) * PROD_W'(mx_s);
   assign prod_bx_in = PROD_W'(coef_bx_ff) * PROD_W'(my_s);
   assign prod_ay_in = PROD_W'(coef_ay_ff) * PROD_W'(mx_s);
   assign prod_by_in = PROD_W'(coef_by_ff) * PROD_W'(my_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else if (advance) begin
         prod_vld_ff <= med_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ax_ff <= prod_ax_in;
         prod_bx_ff <= prod_bx_in;
         prod_ay_ff <= prod_ay_in;
         prod_by_ff <= prod_by_in;
         med3_x_ff  <= med_x_ff;
         med3_y_ff  <= med_y_ff;
      end
   end

   // sum stage
   logic signed [ACC_W-1:0] acc_x_ff, acc_y_ff;
   logic signed [ACC_W-1:0] acc_x_in, acc_y_in;
   logic [SAMPLE_BITS-1:0]  med4_x_ff, med4_y_ff;

   assign acc_x_in = ACC_W'(prod_ax_ff) + ACC_W'(prod_bx_ff) + ACC_W'(offset_dx_ff);
   assign acc_y_in = ACC_W'(prod_ay_ff) + ACC_W'(prod_by_ff) + ACC_W'(offset_dy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= 1'b0;
      end else if (advance) begin
         acc_vld_ff <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_x_ff  <= acc_x_in;
         acc_y_ff  <= acc_y_in;
         med4_x_ff <= med3_x_ff;
         med4_y_ff <= med3_y_ff;
      end
   end

   // truncate toward zero, saturate, or pass medians in raw mode
   logic signed [ACC_W-1:0] quo_x, quo_y;
   logic [16:0]             raw_x_w, raw_y_w;
   tmac_pkg::point_type     point_x_in, point_y_in;
   tmac_pkg::point_type     point_x_ff, point_y_ff;

   assign quo_x = (acc_x_ff + (acc_x_ff[ACC_W-1] ? RND_BIAS : NO_BIAS)) >>> FRAC_BITS;
   assign quo_y = (acc_y_ff + (acc_y_ff[ACC_W-1] ? RND_BIAS : NO_BIAS)) >>> FRAC_BITS;
   assign raw_x_w = 17'(med4_x_ff);
   assign raw_y_w = 17'(med4_y_ff);

   always_comb begin
      if (raw_mode_ff) begin
         point_x_in = (raw_x_w > 17'd32767) ? 16'sh7FFF : raw_x_w[15:0];
         point_y_in = (raw_y_w > 17'd32767) ? 16'sh7FFF : raw_y_w[15:0];
      end else begin
         priority if (quo_x > SAT_HI) begin
            point_x_in = 16'sh7FFF;
         end else if (quo_x < SAT_LO) begin
            point_x_in = 16'sh8000;
         end else begin
            point_x_in = quo_x[15:0];
         end
         priority if (quo_y > SAT_HI) begin
            point_y_in = 16'sh7FFF;
         end else if (quo_y < SAT_LO) begin
            point_y_in = 16'sh8000;
         end else begin
            point_y_in = quo_y[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= acc_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         point_x_ff <= point_x_in;
         point_y_ff <= point_y_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.point_x = point_x_ff;
   assign rsp_ch.point_y = point_y_ff;

`ifndef ASSERT_OFF
   // groups are seven words apart, so the four-stage pipe never holds two
   a_single_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0({fire_ff, med_vld_ff, prod_vld_ff, acc_vld_ff}))
      else $error("more than one group in flight");

   a_pen_up_restart: assert property (@(posedge clock) disable iff (reset)
      (take && !req_ch.pen_down) |=> (!fire_ff && count_ff == '0))
      else $error("pen up did not restart the group");

   a_fire_clears_count: assert property (@(posedge clock) disable iff (reset)
      fire_ff |-> (count_ff == '0))
      else $error("group count not cleared after a full group");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < tmac_pkg::CNT_W'(tmac_pkg::GROUP_LEN))
      else $error("group count beyond group length");
`endif

endmodule

// File: bench/touch_median7_affine_calibrate_top_tb.sv
// self-checking bench for the touch median-of-seven filter with affine calibration
module touch_median7_affine_calibrate_top_tb;

   localparam int SAMPLE_BITS = 12;
   localparam int FRAC_BITS   = 16;
   localparam int IDLE_PCT    = 17;
   localparam int HOLD_CYCLES = 150;
   localparam int SETTLE      = 10;
   localparam logic [tmac_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

   // exchange pairs of the median network, leftmost first
   localparam logic [0:tmac_pkg::NET_LEN-1][2:0] EXCH_LO = {
      3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd3, 3'd2, 3'd2, 3'd3, 3'd4, 3'd1, 3'd1, 3'd3
   };
   localparam logic [0:tmac_pkg::NET_LEN-1][2:0] EXCH_HI = {
      3'd5, 3'd3, 3'd6, 3'd4, 3'd1, 3'd5, 3'd6, 3'd3, 3'd6, 3'd5, 3'd4, 3'd3, 3'd4
   };

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] raw_x;
      logic [SAMPLE_BITS-1:0] raw_y;
      logic                   pen_down;
   } touch_word_type;

   typedef struct packed {
      tmac_pkg::point_type point_x;
      tmac_pkg::point_type point_y;
   } touch_point_type;

   typedef logic [tmac_pkg::GROUP_LEN-1:0][SAMPLE_BITS-1:0] sample_group_type;

   typedef enum int {
      CAL_DEFAULT,
      CAL_SCREEN,
      CAL_WILD,
      CAL_EXTREME,
      CAL_RAW
   } cal_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   drv_valid    = 1'b0;
   logic [SAMPLE_BITS-1:0] drv_raw_x    = '0;
   logic [SAMPLE_BITS-1:0] drv_raw_y    = '0;
   logic                   drv_pen_down = 1'b0;
   logic                   rsp_ready    = 1'b0;

   logic                           csr_we    = 1'b0;
   logic [tmac_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tmac_pkg::COEF_W-1:0]    csr_wdata = '0;

   tmac_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   tmac_rsp_if                              rsp_ch ();

   assign req_ch.valid    = drv_valid;
   assign req_ch.raw_x    = drv_raw_x;
   assign req_ch.raw_y    = drv_raw_y;
   assign req_ch.pen_down = drv_pen_down;
   assign rsp_ch.ready    = rsp_ready;

   touch_median7_affine_calibrate_top #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .rsp_ch   (rsp_ch),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bench copy of the block state and calibration
   tmac_pkg::coef_type cal_ax = tmac_pkg::COEF_UNITY;
   tmac_pkg::coef_type cal_bx = '0;
   tmac_pkg::coef_type cal_dx = '0;
   tmac_pkg::coef_type cal_ay = '0;
   tmac_pkg::coef_type cal_by = tmac_pkg::COEF_UNITY;
   tmac_pkg::coef_type cal_dy = '0;
   logic               cal_raw = 1'b0;

   sample_group_type x_hist;
   sample_group_type y_hist;
   int unsigned      group_fill = 0;

   touch_word_type  pending_words [$];
   touch_point_type expected_points [$];
   touch_word_type  cur_word;
   int unsigned     words_queued = 0;
   int unsigned     words_taken  = 0;
   int unsigned     error_count  = 0;
   bit              no_idle      = 1'b0;
   int unsigned     hold_asks    = 0;
   int unsigned     hold_served  = 0;
   int unsigned     hold_left    = 0;

   function automatic logic [SAMPLE_BITS-1:0] median_of_group(input sample_group_type v);
      sample_group_type       s;
      logic [SAMPLE_BITS-1:0] t;
      s = v;
      for (int k = 0; k < tmac_pkg::NET_LEN; k++) begin
         if (s[EXCH_LO[k]] > s[EXCH_HI[k]]) begin
            t = s[EXCH_LO[k]];
            s[EXCH_LO[k]] = s[EXCH_HI[k]];
            s[EXCH_HI[k]] = t;
         end
      end
      return s[tmac_pkg::MEDIAN_SEL];
   endfunction

   function automatic tmac_pkg::point_type clamp_point(input longint v);
      if (v > 32767)
         return 16'sh7FFF;
      if (v < -32768)
         return 16'sh8000;
      return tmac_pkg::point_type'(v);
   endfunction

   // sum is exact in 64 bits, the divide truncates toward zero
   function automatic tmac_pkg::point_type affine_axis(input logic [SAMPLE_BITS-1:0] mx,
                                                       input logic [SAMPLE_BITS-1:0] my,
                                                       input tmac_pkg::coef_type a,
                                                       input tmac_pkg::coef_type b,
                                                       input tmac_pkg::coef_type d);
      longint acc;
      longint scale;
      scale = longint'(1) << FRAC_BITS;
      acc = longint'(a) * longint'(mx) + longint'(b) * longint'(my) + longint'(d);
      return clamp_point(acc / scale);
   endfunction

   task automatic predict_word(input touch_word_type w);
      logic [SAMPLE_BITS-1:0] mx;
      logic [SAMPLE_BITS-1:0] my;
      touch_point_type        p;
      if (!w.pen_down) begin
         group_fill = 0;
         return;
      end
      x_hist[group_fill] = w.raw_x;
      y_hist[group_fill] = w.raw_y;
      group_fill++;
      if (group_fill < tmac_pkg::GROUP_LEN)
         return;
      group_fill = 0;
      mx = median_of_group(x_hist);
      my = median_of_group(y_hist);
      if (cal_raw) begin
         p.point_x = clamp_point(longint'(mx));
         p.point_y = clamp_point(longint'(my));
      end else begin
         p.point_x = affine_axis(mx, my, cal_ax, cal_bx, cal_dx);
         p.point_y = affine_axis(mx, my, cal_ay, cal_by, cal_dy);
      end
      expected_points.push_back(p);
   endtask

   // sender: holds a word until taken, idles only between words
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_ch.ready) begin
            predict_word(cur_word);
            words_taken++;
         end
         if (!drv_valid || req_ch.ready) begin
            if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
               cur_word = pending_words.pop_front();
               drv_valid    <= 1'b1;
               drv_raw_x    <= cur_word.raw_x;
               drv_raw_y    <= cur_word.raw_y;
               drv_pen_down <= cur_word.pen_down;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each point taken, stalls at random or for a long hold-off
   always @(posedge clock) begin
      touch_point_type want;
      if (!reset && rsp_ch.valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected point (%0d,%0d)", rsp_ch.point_x, rsp_ch.point_y);
         end else begin
            want = expected_points.pop_front();
            if (rsp_ch.point_x !== want.point_x || rsp_ch.point_y !== want.point_y) begin
               error_count++;
               if (error_count <= 10)
                  $display("point mismatch: expected (%0d,%0d) got (%0d,%0d)",
                           want.point_x, want.point_y, rsp_ch.point_x, rsp_ch.point_y);
            end
         end
      end
      if (hold_asks != hold_served) begin
         hold_served = hold_asks;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || $urandom_range(99) >= IDLE_PCT;
      end
   end

   task automatic push_word(input logic [SAMPLE_BITS-1:0] x, input logic [SAMPLE_BITS-1:0] y,
                            input logic pen);
      touch_word_type w;
      w.raw_x    = x;
      w.raw_y    = y;
      w.pen_down = pen;
      pending_words.push_back(w);
      words_queued++;
   endtask

   task automatic wait_idle();
      while (words_taken != words_queued || expected_points.size() != 0)
         @(posedge clock);
      // a partial group may still be in flight with no point to show for it
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tmac_pkg::CSR_IDX_W-1:0] idx,
                            input logic [tmac_pkg::COEF_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         tmac_pkg::CSR_COEF_AX:   cal_ax = value;
         tmac_pkg::CSR_COEF_BX:   cal_bx = value;
         tmac_pkg::CSR_OFFSET_DX: cal_dx = value;
         tmac_pkg::CSR_COEF_AY:   cal_ay = value;
         tmac_pkg::CSR_COEF_BY:   cal_by = value;
         tmac_pkg::CSR_OFFSET_DY: cal_dy = value;
         tmac_pkg::CSR_RAW_MODE:  cal_raw = value[0];
         default: ;
      endcase
   endtask

   function automatic tmac_pkg::coef_type rand_span(input int unsigned span);
      return tmac_pkg::coef_type'(int'($urandom_range(2 * span, 0)) - int'(span));
   endfunction

   function automatic tmac_pkg::coef_type pick_extreme();
      case ($urandom_range(4))
         0: return tmac_pkg::coef_type'(32'h7FFF_FFFF);
         1: return tmac_pkg::coef_type'(32'h8000_0000);
         2: return '0;
         3: return tmac_pkg::COEF_UNITY;
         default: return -tmac_pkg::COEF_UNITY;
      endcase
   endfunction

   task automatic load_calibration(input cal_mode_type mode);
      tmac_pkg::coef_type v [6];
      logic               raw;
      logic [31:0]        raw_word;
      raw = 1'b0;
      case (mode)
         CAL_DEFAULT: begin
            v = '{tmac_pkg::COEF_UNITY, 0, 0, 0, tmac_pkg::COEF_UNITY, 0};
         end
         CAL_SCREEN: begin
            // gains within two of zero, cross terms within one eighth, offsets within a thousand pixels
            v[0] = rand_span(2 * 65536);
            v[1] = rand_span(8192);
            v[2] = rand_span(1000 * 65536);
            v[3] = rand_span(8192);
            v[4] = rand_span(2 * 65536);
            v[5] = rand_span(1000 * 65536);
         end
         CAL_EXTREME: begin
            for (int k = 0; k < 6; k++)
               v[k] = pick_extreme();
         end
         default: begin
            for (int k = 0; k < 6; k++)
               v[k] = tmac_pkg::coef_type'($urandom);
            raw = (mode == CAL_RAW);
         end
      endcase
      write_reg(tmac_pkg::CSR_COEF_AX, v[0]);
      write_reg(tmac_pkg::CSR_COEF_BX, v[1]);
      write_reg(tmac_pkg::CSR_OFFSET_DX, v[2]);
      write_reg(tmac_pkg::CSR_COEF_AY, v[3]);
      write_reg(tmac_pkg::CSR_COEF_BY, v[4]);
      write_reg(tmac_pkg::CSR_OFFSET_DY, v[5]);
      // upper bits of the mode word must be ignored
      raw_word    = $urandom;
      raw_word[0] = raw;
      write_reg(tmac_pkg::CSR_RAW_MODE, raw_word);
      write_reg(CSR_UNUSED_IDX, $urandom);
   endtask

   function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int style,
                                                          input logic [SAMPLE_BITS-1:0] centre);
      int v;
      case (style)
         0: return SAMPLE_BITS'($urandom);
         1: begin
            // jittery touch around one spot with the odd outlier
            if ($urandom_range(7) == 0)
               return SAMPLE_BITS'($urandom);
            v = int'(centre) + int'($urandom_range(64)) - 32;
            if (v < 0)
               v = 0;
            if (v > int'(SAMPLE_MAX))
               v = int'(SAMPLE_MAX);
            return SAMPLE_BITS'(v);
         end
         default: return $urandom_range(1) ? SAMPLE_MAX : '0;
      endcase
   endfunction

   task automatic run_traffic(input int unsigned n_down);
      int unsigned            pushed;
      int unsigned            in_group;
      int                     style;
      logic [SAMPLE_BITS-1:0] cx;
      logic [SAMPLE_BITS-1:0] cy;
      pushed   = 0;
      in_group = 0;
      while (pushed < n_down) begin
         if (in_group == 0) begin
            style = ($urandom_range(9) < 6) ? 1 : $urandom_range(2) == 0 ? 2 : 0;
            cx    = SAMPLE_BITS'($urandom);
            cy    = SAMPLE_BITS'($urandom);
         end
         if ($urandom_range(24) == 0) begin
            // pen lift breaks the current group
            push_word(SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom), 1'b0);
            in_group = 0;
         end else begin
            push_word(pick_sample(style, cx), pick_sample(style, cy), 1'b1);
            pushed++;
            in_group = (in_group + 1) % tmac_pkg::GROUP_LEN;
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration, field extremes and mixed patterns in one group
      push_word('0, SAMPLE_MAX, 1'b1);
      push_word(SAMPLE_MAX, '0, 1'b1);
      push_word(12'd1, 12'd4094, 1'b1);
      push_word(12'd4094, 12'd1, 1'b1);
      push_word(12'd2048, 12'd2047, 1'b1);
      push_word(12'hAAA, 12'h555, 1'b1);
      push_word(12'h555, 12'hAAA, 1'b1);
      // pen up part way through a group discards it
      push_word(12'd100, 12'd200, 1'b1);
      push_word(12'd300, 12'd400, 1'b1);
      push_word(12'd500, 12'd600, 1'b1);
      push_word(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
      wait_idle();

      // raw mode with stray upper bits in the mode word
      write_reg(tmac_pkg::CSR_RAW_MODE, 32'hFFFF_FFFF);
      for (int k = 0; k < tmac_pkg::GROUP_LEN; k++)
         push_word(SAMPLE_MAX, '0, 1'b1);
      wait_idle();

      // calibration overflow both ways, mode cleared with upper bits set
      write_reg(tmac_pkg::CSR_RAW_MODE, 32'hFFFF_FFFE);
      write_reg(tmac_pkg::CSR_COEF_AX, 32'h7FFF_FFFF);
      write_reg(tmac_pkg::CSR_COEF_BX, 32'h7FFF_FFFF);
      write_reg(tmac_pkg::CSR_OFFSET_DX, 32'h7FFF_FFFF);
      write_reg(tmac_pkg::CSR_COEF_AY, 32'h8000_0000);
      write_reg(tmac_pkg::CSR_COEF_BY, 32'h8000_0000);
      write_reg(tmac_pkg::CSR_OFFSET_DY, 32'h8000_0000);
      write_reg(CSR_UNUSED_IDX, 32'h0BAD_F00D);
      for (int k = 0; k < tmac_pkg::GROUP_LEN; k++)
         push_word(SAMPLE_BITS'($urandom_range(4095, 512)),
                   SAMPLE_BITS'($urandom_range(4095, 512)), 1'b1);
      wait_idle();

      load_calibration(CAL_DEFAULT);
      run_traffic(125);
      load_calibration(CAL_SCREEN);
      run_traffic(125);
      no_idle = 1'b1;
      load_calibration(CAL_WILD);
      run_traffic(125);
      no_idle = 1'b0;
      load_calibration(CAL_EXTREME);
      hold_asks++;
      run_traffic(125);
      load_calibration(CAL_RAW);
      run_traffic(125);
      load_calibration(CAL_SCREEN);
      run_traffic(125);

      if (error_count == 0 && expected_points.size() == 0)
         $display("PASS touch_median7_affine_calibrate_top");
      else
         $display("FAIL touch_median7_affine_calibrate_top");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL touch_median7_affine_calibrate_top");
      $finish;
   end

endmodule

// File: touch_median7_affine_calibrate_top.f
rtl/tmac_pkg.sv
rtl/tmac_req_if.sv
rtl/tmac_rsp_if.sv
rtl/tmac_median7.sv
rtl/touch_median7_affine_calibrate_top.sv
bench/touch_median7_affine_calibrate_top_tb.sv
